// ----- design/dam_pkg.sv -----
// Shared types and constants of the DRAM address mapper.
package dam_pkg;

    // Widths of field positions and field sizes inside the pipeline
    localparam int POS_W  = 7;
    localparam int SIZE_W = 5;
    localparam int INS_W  = 3;

    // Mapping policy codes
    localparam logic [2:0] POLICY_OPEN_PAGE  = 3'd0;
    localparam logic [2:0] POLICY_CLOSE_PAGE = 3'd1;
    localparam logic [2:0] POLICY_INTERLEAVE = 3'd2;
    localparam logic [2:0] POLICY_ROW_COL_BK = 3'd3;
    localparam logic [2:0] POLICY_BK_ROW_COL = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_MAPPING_POLICY  = 3'd0;
    localparam logic [2:0] REG_BANK_BITS       = 3'd1;
    localparam logic [2:0] REG_GROUP_BANK_BITS = 3'd2;
    localparam logic [2:0] REG_COLUMN_BITS     = 3'd3;
    localparam logic [2:0] REG_ROW_BITS        = 3'd4;
    localparam logic [2:0] REG_OFFSET_BITS     = 3'd5;

    // Reset values of the configuration registers
    localparam logic [2:0] RST_MAPPING_POLICY  = 3'd0;
    localparam logic [2:0] RST_BANK_BITS       = 3'd4;
    localparam logic [2:0] RST_GROUP_BANK_BITS = 3'd2;
    localparam logic [3:0] RST_COLUMN_BITS     = 4'd10;
    localparam logic [4:0] RST_ROW_BITS        = 5'd14;
    localparam logic [3:0] RST_OFFSET_BITS     = 4'd6;

    typedef struct packed {
        logic [2:0] mapping_policy;
        logic [2:0] bank_bits;
        logic [2:0] group_bank_bits;
        logic [3:0] column_bits;
        logic [4:0] row_bits;
        logic [3:0] offset_bits;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [SIZE_W-1:0] size;
    } field_t;

    typedef struct packed {
        field_t            col;
        field_t            bank;
        field_t            row;
        logic              col_dbl;
        logic              ins_en;
        logic [INS_W-1:0]  ins_pos;
        logic [POS_W-1:0]  lowg_pos;
    } ctrl_t;

endpackage

// ----- design/dram_address_mapper.sv -----
// Top level of the DRAM address mapper: configuration registers and the decode pipeline.
//
// Usage:
//   Pulse start with a physical address on phys_address; the word is taken at any
//   rising edge where start is high and busy is low. busy stays low, so a new
//   address may be presented in every cycle.
//   Once the word has passed the decode, extract and assemble registers, done
//   is high for exactly one cycle with bank_index, row_index and column_index;
//   the receiver takes the word on that edge and cannot hold it off, so nothing
//   ever waits inside the block. Three stages (decode of field positions, field
//   shifters, mask and bank rebuild) take one address per cycle.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   in the same edge (0 policy, 1 bank bits, 2 group bank bits, 3 column bits,
//   4 row bits, 5 offset bits); other indexes are ignored. Write only while no
//   address is in flight.
//   Reset (rst_n low, asynchronous) empties the pipeline and loads the
//   configuration defaults: open page, 16 banks, 4 per group, 1024 columns,
//   16384 rows, 6 offset bits.
module dram_address_mapper #(
    parameter int MAX_BANK_BITS   = 5,
    parameter int MAX_ROW_BITS    = 17,
    parameter int MAX_COLUMN_BITS = 11,
    parameter int ADDRESS_BITS    = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        start,
    output logic                        busy,
    input  logic [ADDRESS_BITS-1:0]     phys_address,
    // result channel
    output logic                        done,
    output logic [MAX_BANK_BITS-1:0]    bank_index,
    output logic [MAX_ROW_BITS-1:0]     row_index,
    output logic [MAX_COLUMN_BITS-1:0]  column_index,
    // configuration write port
    input  logic                        cfg_write,
    input  logic [2:0]                  cfg_index,
    input  logic [4:0]                  cfg_data
);

    dam_pkg::cfg_t               cfg_reg;
    dam_pkg::cfg_t               cfg_next;
    logic                        accept;

    logic                        s1_valid;
    logic [ADDRESS_BITS-1:0]     s1_addr;
    dam_pkg::ctrl_t              s1_ctrl;

    logic                        s2_valid;
    dam_pkg::ctrl_t              s2_ctrl;
    logic [MAX_COLUMN_BITS-1:0]  s2_col;
    logic [MAX_BANK_BITS-1:0]    s2_bank;
    logic [MAX_ROW_BITS-1:0]     s2_row;
    logic                        s2_lowg;

    // The pipeline never stalls, so the request side is always open
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers: write one field per cycle, ignore unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                dam_pkg::REG_MAPPING_POLICY:  cfg_next.mapping_policy  = cfg_data[2:0];
                dam_pkg::REG_BANK_BITS:       cfg_next.bank_bits       = cfg_data[2:0];
                dam_pkg::REG_GROUP_BANK_BITS: cfg_next.group_bank_bits = cfg_data[2:0];
                dam_pkg::REG_COLUMN_BITS:     cfg_next.column_bits     = cfg_data[3:0];
                dam_pkg::REG_ROW_BITS:        cfg_next.row_bits        = cfg_data;
                dam_pkg::REG_OFFSET_BITS:     cfg_next.offset_bits     = cfg_data[3:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mapping_policy  <= dam_pkg::RST_MAPPING_POLICY;
            cfg_reg.bank_bits       <= dam_pkg::RST_BANK_BITS;
            cfg_reg.group_bank_bits <= dam_pkg::RST_GROUP_BANK_BITS;
            cfg_reg.column_bits     <= dam_pkg::RST_COLUMN_BITS;
            cfg_reg.row_bits        <= dam_pkg::RST_ROW_BITS;
            cfg_reg.offset_bits     <= dam_pkg::RST_OFFSET_BITS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Stage 1: field positions and sizes
    dam_decode #(
        .MAX_BANK_BITS   (MAX_BANK_BITS),
        .MAX_ROW_BITS    (MAX_ROW_BITS),
        .MAX_COLUMN_BITS (MAX_COLUMN_BITS),
        .ADDRESS_BITS    (ADDRESS_BITS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .addr_in   (phys_address),
        .cfg       (cfg_reg),
        .valid_out (s1_valid),
        .addr_out  (s1_addr),
        .ctrl_out  (s1_ctrl)
    );

    // Stage 2: field shifters
    dam_extract #(
        .MAX_BANK_BITS   (MAX_BANK_BITS),
        .MAX_ROW_BITS    (MAX_ROW_BITS),
        .MAX_COLUMN_BITS (MAX_COLUMN_BITS),
        .ADDRESS_BITS    (ADDRESS_BITS)
    ) u_extract (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid),
        .addr_in   (s1_addr),
        .ctrl_in   (s1_ctrl),
        .valid_out (s2_valid),
        .ctrl_out  (s2_ctrl),
        .col_raw   (s2_col),
        .bank_raw  (s2_bank),
        .row_raw   (s2_row),
        .lowg      (s2_lowg)
    );

    // Stage 3: masks, column doubling, bank rebuild
    dam_assemble #(
        .MAX_BANK_BITS   (MAX_BANK_BITS),
        .MAX_ROW_BITS    (MAX_ROW_BITS),
        .MAX_COLUMN_BITS (MAX_COLUMN_BITS)
    ) u_assemble (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .ctrl      (s2_ctrl),
        .col_raw   (s2_col),
        .bank_raw  (s2_bank),
        .row_raw   (s2_row),
        .lowg      (s2_lowg),
        .valid_out (done),
        .bank      (bank_index),
        .row       (row_index),
        .column    (column_index)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("accepted word did not complete in three cycles");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result word without a matching request");

endmodule

// ----- design/dam_decode.sv -----
// Stage 1: turn the configuration into field positions and sizes for one word.
module dam_decode #(
    parameter int MAX_BANK_BITS   = 5,
    parameter int MAX_ROW_BITS    = 17,
    parameter int MAX_COLUMN_BITS = 11,
    parameter int ADDRESS_BITS    = 48
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     valid_in,
    input  logic [ADDRESS_BITS-1:0]  addr_in,
    input  dam_pkg::cfg_t            cfg,
    output logic                     valid_out,
    output logic [ADDRESS_BITS-1:0]  addr_out,
    output dam_pkg::ctrl_t           ctrl_out
);

    logic                         valid_reg;
    logic [ADDRESS_BITS-1:0]      addr_reg;
    dam_pkg::ctrl_t               ctrl_reg;
    dam_pkg::ctrl_t               ctrl_next;

    logic [dam_pkg::SIZE_W-1:0]   b_sat;
    logic [dam_pkg::SIZE_W-1:0]   g_sat;
    logic [dam_pkg::SIZE_W-1:0]   c_sat;
    logic [dam_pkg::SIZE_W-1:0]   r_sat;
    logic [dam_pkg::SIZE_W-1:0]   ch_sat;
    logic                         split;
    logic [dam_pkg::POS_W-1:0]    o_pos;
    logic [dam_pkg::POS_W-1:0]    b_pos;
    logic [dam_pkg::POS_W-1:0]    c_pos;
    logic [dam_pkg::POS_W-1:0]    r_pos;
    logic [dam_pkg::POS_W-1:0]    ch_pos;
    logic [dam_pkg::POS_W-1:0]    s_pos;
    logic [dam_pkg::POS_W-1:0]    bs_pos;

    always_comb
    begin
        // Saturate the sizes
        b_sat = (dam_pkg::SIZE_W'(cfg.bank_bits) > dam_pkg::SIZE_W'(MAX_BANK_BITS)) ?
                dam_pkg::SIZE_W'(MAX_BANK_BITS) : dam_pkg::SIZE_W'(cfg.bank_bits);
        g_sat = (dam_pkg::SIZE_W'(cfg.group_bank_bits) > b_sat) ?
                b_sat : dam_pkg::SIZE_W'(cfg.group_bank_bits);
        c_sat = (dam_pkg::SIZE_W'(cfg.column_bits) > dam_pkg::SIZE_W'(MAX_COLUMN_BITS)) ?
                dam_pkg::SIZE_W'(MAX_COLUMN_BITS) : dam_pkg::SIZE_W'(cfg.column_bits);
        r_sat = (cfg.row_bits > dam_pkg::SIZE_W'(MAX_ROW_BITS)) ?
                dam_pkg::SIZE_W'(MAX_ROW_BITS) : cfg.row_bits;
        ch_sat = (c_sat == '0) ? '0 : c_sat - dam_pkg::SIZE_W'(1);
        split  = (b_sat > g_sat);

        o_pos  = dam_pkg::POS_W'(cfg.offset_bits);
        b_pos  = dam_pkg::POS_W'(b_sat);
        c_pos  = dam_pkg::POS_W'(c_sat);
        r_pos  = dam_pkg::POS_W'(r_sat);
        ch_pos = dam_pkg::POS_W'(ch_sat);
        s_pos  = o_pos + dam_pkg::POS_W'(split);
        bs_pos = s_pos + ch_pos;

        ctrl_next          = '0;
        ctrl_next.lowg_pos = o_pos;
        ctrl_next.ins_pos  = g_sat[dam_pkg::INS_W-1:0];

        case (cfg.mapping_policy)
            dam_pkg::POLICY_OPEN_PAGE:
            begin
                ctrl_next.col.pos   = o_pos + c_pos;
                ctrl_next.col.size  = c_sat;
                ctrl_next.bank.pos  = o_pos + c_pos + b_pos;
                ctrl_next.bank.size = b_sat;
                ctrl_next.row.pos   = o_pos + c_pos + b_pos + r_pos;
                ctrl_next.row.size  = r_sat;
            end
            dam_pkg::POLICY_CLOSE_PAGE:
            begin
                ctrl_next.bank.pos  = o_pos + b_pos;
                ctrl_next.bank.size = b_sat;
                ctrl_next.col.pos   = o_pos + b_pos + c_pos;
                ctrl_next.col.size  = c_sat;
                ctrl_next.row.pos   = o_pos + b_pos + c_pos + r_pos;
                ctrl_next.row.size  = r_sat;
            end
            dam_pkg::POLICY_INTERLEAVE:
            begin
                ctrl_next.col.pos   = s_pos;
                ctrl_next.col.size  = ch_sat;
                ctrl_next.col_dbl   = 1'b1;
                ctrl_next.bank.pos  = bs_pos;
                ctrl_next.bank.size = b_sat - dam_pkg::SIZE_W'(split);
                ctrl_next.ins_en    = split;
                ctrl_next.row.pos   = bs_pos + b_pos - dam_pkg::POS_W'(split);
                ctrl_next.row.size  = r_sat;
            end
            dam_pkg::POLICY_ROW_COL_BK:
            begin
                ctrl_next.bank.pos  = o_pos;
                ctrl_next.bank.size = b_sat;
                ctrl_next.col.pos   = o_pos + b_pos;
                ctrl_next.col.size  = ch_sat;
                ctrl_next.col_dbl   = 1'b1;
                ctrl_next.row.pos   = o_pos + b_pos + ch_pos;
                ctrl_next.row.size  = r_sat;
            end
            dam_pkg::POLICY_BK_ROW_COL:
            begin
                ctrl_next.col.pos   = o_pos;
                ctrl_next.col.size  = ch_sat;
                ctrl_next.col_dbl   = 1'b1;
                ctrl_next.row.pos   = o_pos + ch_pos;
                ctrl_next.row.size  = r_sat;
                ctrl_next.bank.pos  = o_pos + ch_pos + r_pos;
                ctrl_next.bank.size = b_sat;
            end
            default:
            begin
                ctrl_next.lowg_pos = o_pos;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_in;
        ctrl_reg <= ctrl_next;
    end

    assign valid_out = valid_reg;
    assign addr_out  = addr_reg;
    assign ctrl_out  = ctrl_reg;

    a_sizes_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (ctrl_reg.bank.size <= dam_pkg::SIZE_W'(MAX_BANK_BITS)) &&
                      (ctrl_reg.row.size <= dam_pkg::SIZE_W'(MAX_ROW_BITS)) &&
                      (ctrl_reg.col.size <= dam_pkg::SIZE_W'(MAX_COLUMN_BITS)))
        else $error("field size above its maximum");

endmodule

// ----- design/dam_extract.sv -----
// Stage 2: shift each field of the address down to bit zero.
module dam_extract #(
    parameter int MAX_BANK_BITS   = 5,
    parameter int MAX_ROW_BITS    = 17,
    parameter int MAX_COLUMN_BITS = 11,
    parameter int ADDRESS_BITS    = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid_in,
    input  logic [ADDRESS_BITS-1:0]     addr_in,
    input  dam_pkg::ctrl_t              ctrl_in,
    output logic                        valid_out,
    output dam_pkg::ctrl_t              ctrl_out,
    output logic [MAX_COLUMN_BITS-1:0]  col_raw,
    output logic [MAX_BANK_BITS-1:0]    bank_raw,
    output logic [MAX_ROW_BITS-1:0]     row_raw,
    output logic                        lowg
);

    logic                        valid_reg;
    dam_pkg::ctrl_t              ctrl_reg;
    logic [MAX_COLUMN_BITS-1:0]  col_raw_reg;
    logic [MAX_BANK_BITS-1:0]    bank_raw_reg;
    logic [MAX_ROW_BITS-1:0]     row_raw_reg;
    logic                        lowg_reg;

    logic [ADDRESS_BITS-1:0]     col_sh;
    logic [ADDRESS_BITS-1:0]     bank_sh;
    logic [ADDRESS_BITS-1:0]     row_sh;
    logic [ADDRESS_BITS-1:0]     lowg_sh;

    // A position past the top of the address shifts everything out
    assign col_sh  = addr_in >> ctrl_in.col.pos;
    assign bank_sh = addr_in >> ctrl_in.bank.pos;
    assign row_sh  = addr_in >> ctrl_in.row.pos;
    assign lowg_sh = addr_in >> ctrl_in.lowg_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg     <= ctrl_in;
        col_raw_reg  <= col_sh[MAX_COLUMN_BITS-1:0];
        bank_raw_reg <= bank_sh[MAX_BANK_BITS-1:0];
        row_raw_reg  <= row_sh[MAX_ROW_BITS-1:0];
        lowg_reg     <= lowg_sh[0];
    end

    assign valid_out = valid_reg;
    assign ctrl_out  = ctrl_reg;
    assign col_raw   = col_raw_reg;
    assign bank_raw  = bank_raw_reg;
    assign row_raw   = row_raw_reg;
    assign lowg      = lowg_reg;

endmodule

// ----- design/dam_assemble.sv -----
// Stage 3: mask the fields to size, double the column when col_dbl is set and rebuild a split bank.
module dam_assemble #(
    parameter int MAX_BANK_BITS   = 5,
    parameter int MAX_ROW_BITS    = 17,
    parameter int MAX_COLUMN_BITS = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid_in,
    input  dam_pkg::ctrl_t              ctrl,
    input  logic [MAX_COLUMN_BITS-1:0]  col_raw,
    input  logic [MAX_BANK_BITS-1:0]    bank_raw,
    input  logic [MAX_ROW_BITS-1:0]     row_raw,
    input  logic                        lowg,
    output logic                        valid_out,
    output logic [MAX_BANK_BITS-1:0]    bank,
    output logic [MAX_ROW_BITS-1:0]     row,
    output logic [MAX_COLUMN_BITS-1:0]  column
);

    logic                        valid_reg;
    logic [MAX_BANK_BITS-1:0]    bank_reg;
    logic [MAX_BANK_BITS-1:0]    bank_next;
    logic [MAX_ROW_BITS-1:0]     row_reg;
    logic [MAX_ROW_BITS-1:0]     row_next;
    logic [MAX_COLUMN_BITS-1:0]  column_reg;
    logic [MAX_COLUMN_BITS-1:0]  column_next;

    logic [MAX_COLUMN_BITS-1:0]  col_keep;
    logic [MAX_BANK_BITS-1:0]    bank_keep;
    logic [MAX_BANK_BITS-1:0]    lo_mask;
    logic [MAX_ROW_BITS-1:0]     row_keep;
    logic [MAX_COLUMN_BITS-1:0]  col_val;
    logic [MAX_BANK_BITS-1:0]    bank_val;
    logic [MAX_BANK_BITS-1:0]    bank_hi;

    always_comb
    begin
        for (int i = 0; i < MAX_COLUMN_BITS; i++)
        begin
            col_keep[i] = (dam_pkg::SIZE_W'(i) < ctrl.col.size);
        end
        for (int i = 0; i < MAX_BANK_BITS; i++)
        begin
            bank_keep[i] = (dam_pkg::SIZE_W'(i) < ctrl.bank.size);
            lo_mask[i]   = (dam_pkg::INS_W'(i) < ctrl.ins_pos);
        end
        for (int i = 0; i < MAX_ROW_BITS; i++)
        begin
            row_keep[i] = (dam_pkg::SIZE_W'(i) < ctrl.row.size);
        end

        col_val  = col_raw & col_keep;
        bank_val = bank_raw & bank_keep;
        row_next = row_raw & row_keep;

        column_next = ctrl.col_dbl ? (col_val << 1) : col_val;

        // Split group: push the upper bank bits up by one and drop the low
        // group bit into the gap above the in-group bits
        bank_hi = bank_val >> ctrl.ins_pos;
        if (ctrl.ins_en)
        begin
            bank_next = (((bank_hi << 1) | MAX_BANK_BITS'(lowg)) << ctrl.ins_pos) |
                        (bank_val & lo_mask);
        end
        else
        begin
            bank_next = bank_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg   <= bank_next;
        row_reg    <= row_next;
        column_reg <= column_next;
    end

    assign valid_out = valid_reg;
    assign bank      = bank_reg;
    assign row       = row_reg;
    assign column    = column_reg;

    a_column_even: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_in && ctrl.col_dbl) |=> (column_reg[0] == 1'b0))
        else $error("doubled column is odd");

    a_empty_bank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_in && (ctrl.bank.size == '0) && !ctrl.ins_en) |=> (bank_reg == '0))
        else $error("zero-size bank field is not zero");

endmodule
